// File: src/pedestrian_crossing_light_controller_macros.svh
// Assertion macros for the pedestrian crossing light controller checker.
// Depends on nothing; included by the checker file.
`ifndef PEDESTRIAN_CROSSING_LIGHT_CONTROLLER_MACROS_SVH
`define PEDESTRIAN_CROSSING_LIGHT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcl: implication check failed");

// Next-cycle implication, disabled during reset.
`define PCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcl: next-cycle check failed");

`endif

// File: src/pcl_pkg.sv
// Shared types and constants of the pedestrian crossing light controller.
// No dependencies.
`timescale 1ns / 1ps

package pcl_pkg;

   localparam int TIME_BITS_DEFAULT = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int STEP_BITS      = 16;
   localparam int DEBOUNCE_BITS  = 10;
   localparam int BEEP_BITS      = 16;
   localparam int COUNT_BITS     = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP_INTERVAL = 3'd0,
      CSR_DEBOUNCE      = 3'd1,
      CSR_IDLE_BEEP     = 3'd2,
      CSR_WALK_BEEP     = 3'd3,
      CSR_WAIT_START    = 3'd4,
      CSR_WALK_START    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_WAIT  = 2'd1,
      PHASE_WALK  = 2'd2,
      PHASE_CLEAR = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      DISP_IDLE       = 3'd0,
      DISP_WAIT_COUNT = 3'd1,
      DISP_WALK       = 3'd2,
      DISP_WALK_COUNT = 3'd3,
      DISP_BLANK      = 3'd4
   } disp_mode_type;

   typedef enum logic {
      BEEP_LONG  = 1'b0,   // 500 Hz, 500 ms
      BEEP_SHORT = 1'b1    // 880 Hz, 250 ms
   } beep_kind_type;

   typedef struct packed {
      logic [STEP_BITS-1:0]     step_interval_ms;
      logic [DEBOUNCE_BITS-1:0] debounce_ms;
      logic [BEEP_BITS-1:0]     idle_beep_ms;
      logic [BEEP_BITS-1:0]     walk_beep_ms;
      logic [COUNT_BITS-1:0]    wait_start;
      logic [COUNT_BITS-1:0]    walk_start;
   } cfg_type;

   typedef struct packed {
      logic car_red;
      logic car_yellow;
      logic car_green;
      logic ped_red;
      logic ped_green;
   } lamp_type;

   typedef struct packed {
      lamp_type              lamps;
      logic                  beep_start;
      beep_kind_type         beep_kind;
      logic                  beep_stop;
      disp_mode_type         display_mode;
      logic [COUNT_BITS-1:0] display_value;
   } rsp_type;

   localparam lamp_type LAMPS_OFF   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
   localparam lamp_type LAMPS_CARS  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
   localparam lamp_type LAMPS_WALK  = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
   localparam lamp_type LAMPS_CLEAR = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

   localparam logic [STEP_BITS-1:0]     STEP_INTERVAL_RESET = 16'd1000;
   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET      = 10'd50;
   localparam logic [BEEP_BITS-1:0]     IDLE_BEEP_RESET     = 16'd1000;
   localparam logic [BEEP_BITS-1:0]     WALK_BEEP_RESET     = 16'd250;
   localparam logic [COUNT_BITS-1:0]    WAIT_START_RESET    = 4'd5;
   localparam logic [COUNT_BITS-1:0]    WALK_START_RESET    = 4'd5;

   // Wait counter is signed: one extra bit so it can reach -1.
   localparam logic [COUNT_BITS:0]      WAIT_LEFT_RESET     = 5'd5;
   localparam logic [COUNT_BITS-1:0]    WALK_LEFT_RESET     = 4'd5;

endpackage

// File: src/pcl_ifs.sv
// Valid/ready channel interfaces of the pedestrian crossing light controller.
// Depends on pcl_pkg.
`timescale 1ns / 1ps

interface pcl_req_if;
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink   (input valid, input button_level, output ready);
endinterface

interface pcl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           car_red;
   logic                           car_yellow;
   logic                           car_green;
   logic                           ped_red;
   logic                           ped_green;
   logic                           beep_start;
   logic                           beep_kind;
   logic                           beep_stop;
   logic [2:0]                     display_mode;
   logic [pcl_pkg::COUNT_BITS-1:0] display_value;

   modport source (output valid, output car_red, output car_yellow, output car_green,
                   output ped_red, output ped_green, output beep_start, output beep_kind,
                   output beep_stop, output display_mode, output display_value,
                   input ready);
   modport sink   (input valid, input car_red, input car_yellow, input car_green,
                   input ped_red, input ped_green, input beep_start, input beep_kind,
                   input beep_stop, input display_mode, input display_value,
                   output ready);
endinterface

interface pcl_csr_if;
   logic                               valid;
   logic                               ready;
   logic [pcl_pkg::CSR_INDEX_BITS-1:0] index;
   logic [pcl_pkg::STEP_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/pcl_csr.sv
// Configuration register file of the pedestrian crossing light controller.
// Depends on pcl_pkg and pcl_csr_if.
`timescale 1ns / 1ps

module pcl_csr (
   input  logic             clock,
   input  logic             reset,
   pcl_csr_if.sink          csr_bus,
   output pcl_pkg::cfg_type cfg
);

   pcl_pkg::cfg_type cfg_ff;
   pcl_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (pcl_pkg::csr_index_type'(csr_bus.index))
            pcl_pkg::CSR_STEP_INTERVAL: cfg_in.step_interval_ms = csr_bus.data;
            pcl_pkg::CSR_DEBOUNCE:
               cfg_in.debounce_ms = csr_bus.data[pcl_pkg::DEBOUNCE_BITS-1:0];
            pcl_pkg::CSR_IDLE_BEEP:     cfg_in.idle_beep_ms = csr_bus.data;
            pcl_pkg::CSR_WALK_BEEP:     cfg_in.walk_beep_ms = csr_bus.data;
            pcl_pkg::CSR_WAIT_START:
               cfg_in.wait_start = csr_bus.data[pcl_pkg::COUNT_BITS-1:0];
            pcl_pkg::CSR_WALK_START:
               cfg_in.walk_start = csr_bus.data[pcl_pkg::COUNT_BITS-1:0];
            default: ;   // unused indexes are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_interval_ms <= pcl_pkg::STEP_INTERVAL_RESET;
         cfg_ff.debounce_ms      <= pcl_pkg::DEBOUNCE_RESET;
         cfg_ff.idle_beep_ms     <= pcl_pkg::IDLE_BEEP_RESET;
         cfg_ff.walk_beep_ms     <= pcl_pkg::WALK_BEEP_RESET;
         cfg_ff.wait_start       <= pcl_pkg::WAIT_START_RESET;
         cfg_ff.walk_start       <= pcl_pkg::WALK_START_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/pcl_core.sv
// Per-tick controller state and its single-pass next-state logic.
// Depends on pcl_pkg.
`timescale 1ns / 1ps

module pcl_core #(
   parameter int TIME_BITS = pcl_pkg::TIME_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tick_en,       // process one tick this cycle
   input  logic             button_level,  // 0 = pressed
   input  pcl_pkg::cfg_type cfg,
   output pcl_pkg::rsp_type result         // result of the tick being processed
);

   localparam int CB = pcl_pkg::COUNT_BITS;

   logic [TIME_BITS-1:0]            time_ff, time_in;
   logic [TIME_BITS-1:0]            last_press_ff, last_press_in;
   logic [TIME_BITS-1:0]            last_step_ff, last_step_in;
   logic [TIME_BITS-1:0]            last_beep_ff, last_beep_in;
   logic                            held_ff, held_in;
   pcl_pkg::phase_type              phase_ff, phase_in;
   logic [CB:0]                     wait_left_ff, wait_left_in;
   logic [CB-1:0]                   walk_left_ff, walk_left_in;
   logic [pcl_pkg::STEP_BITS-1:0]   clear_left_ff, clear_left_in;
   pcl_pkg::lamp_type               lamps_ff, lamps_in;
   pcl_pkg::disp_mode_type          disp_mode_ff, disp_mode_in;
   logic [CB-1:0]                   disp_value_ff, disp_value_in;

   logic                            sample;
   logic                            press;
   pcl_pkg::phase_type              cur_phase;
   logic                            step_due;
   logic                            idle_beep_due;
   logic                            walk_beep_due;
   logic                            beep_start;
   pcl_pkg::beep_kind_type          beep_kind;
   logic                            beep_stop;

   // Shared conditions; time differences wrap.
   assign sample    = (phase_ff != pcl_pkg::PHASE_CLEAR);
   assign press     = sample && !button_level && !held_ff &&
                      ((time_ff - last_press_ff) > TIME_BITS'(cfg.debounce_ms));
   assign cur_phase = press ? pcl_pkg::PHASE_WAIT : phase_ff;
   assign step_due  = (time_ff - last_step_ff) >= TIME_BITS'(cfg.step_interval_ms);
   assign idle_beep_due = (time_ff - last_beep_ff) >= TIME_BITS'(cfg.idle_beep_ms);
   assign walk_beep_due = (time_ff - last_beep_ff) >= TIME_BITS'(cfg.walk_beep_ms);

   // Next state: phase, counters and timestamps.
   always_comb begin
      time_in       = time_ff + TIME_BITS'(1);
      last_press_in = press ? time_ff : last_press_ff;
      held_in       = held_ff;
      if (press) begin
         held_in = 1'b1;
      end else if (sample && button_level) begin
         held_in = 1'b0;
      end
      phase_in      = cur_phase;
      last_step_in  = last_step_ff;
      last_beep_in  = last_beep_ff;
      wait_left_in  = wait_left_ff;
      walk_left_in  = walk_left_ff;
      clear_left_in = clear_left_ff;
      unique case (cur_phase)
         pcl_pkg::PHASE_IDLE: begin
            if (idle_beep_due) begin
               last_beep_in = time_ff;
            end
         end
         pcl_pkg::PHASE_WAIT: begin
            if (step_due) begin
               last_step_in = time_ff;
               if (!wait_left_ff[CB]) begin
                  wait_left_in = wait_left_ff - (CB+1)'(1);
               end else begin
                  phase_in     = pcl_pkg::PHASE_WALK;
                  wait_left_in = {1'b0, cfg.wait_start};
               end
            end
         end
         pcl_pkg::PHASE_WALK: begin
            if (step_due) begin
               last_step_in = time_ff;
               if (walk_left_ff != '0) begin
                  walk_left_in = walk_left_ff - CB'(1);
               end else begin
                  phase_in      = pcl_pkg::PHASE_CLEAR;
                  walk_left_in  = cfg.walk_start;
                  clear_left_in = cfg.step_interval_ms;
               end
            end
            if (walk_beep_due) begin
               last_beep_in = time_ff;
            end
         end
         pcl_pkg::PHASE_CLEAR: begin
            if (clear_left_ff[pcl_pkg::STEP_BITS-1:1] == '0) begin
               clear_left_in = '0;
               phase_in      = pcl_pkg::PHASE_IDLE;
            end else begin
               clear_left_in = clear_left_ff - pcl_pkg::STEP_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   // Outputs: lamps, display and buzzer pulses.
   always_comb begin
      lamps_in      = lamps_ff;
      disp_mode_in  = disp_mode_ff;
      disp_value_in = disp_value_ff;
      beep_start    = 1'b0;
      beep_kind     = pcl_pkg::BEEP_LONG;
      beep_stop     = 1'b0;
      unique case (cur_phase)
         pcl_pkg::PHASE_IDLE: begin
            lamps_in      = pcl_pkg::LAMPS_CARS;
            disp_mode_in  = pcl_pkg::DISP_IDLE;
            disp_value_in = '0;
            beep_start    = idle_beep_due;
         end
         pcl_pkg::PHASE_WAIT: begin
            // lamps are not redrawn while waiting
            if (step_due && !wait_left_ff[CB]) begin
               disp_mode_in  = pcl_pkg::DISP_WAIT_COUNT;
               disp_value_in = wait_left_ff[CB-1:0];
               beep_start    = 1'b1;
            end
         end
         pcl_pkg::PHASE_WALK: begin
            lamps_in      = pcl_pkg::LAMPS_WALK;
            disp_mode_in  = pcl_pkg::DISP_WALK;
            disp_value_in = '0;
            if (step_due) begin
               if (walk_left_ff != '0) begin
                  disp_mode_in  = pcl_pkg::DISP_WALK_COUNT;
                  disp_value_in = walk_left_ff;
               end else begin
                  beep_stop     = 1'b1;
                  lamps_in      = pcl_pkg::LAMPS_CLEAR;
                  disp_mode_in  = pcl_pkg::DISP_BLANK;
                  disp_value_in = '0;
               end
            end
            if (walk_beep_due) begin
               beep_start = 1'b1;
               beep_kind  = pcl_pkg::BEEP_SHORT;
            end
         end
         pcl_pkg::PHASE_CLEAR: begin
            lamps_in      = pcl_pkg::LAMPS_CLEAR;
            disp_mode_in  = pcl_pkg::DISP_BLANK;
            disp_value_in = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      result.lamps         = lamps_in;
      result.beep_start    = beep_start;
      result.beep_kind     = beep_kind;
      result.beep_stop     = beep_stop;
      result.display_mode  = disp_mode_in;
      result.display_value = (disp_mode_in == pcl_pkg::DISP_WAIT_COUNT ||
                              disp_mode_in == pcl_pkg::DISP_WALK_COUNT) ?
                             disp_value_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         last_press_ff <= '0;
         last_step_ff  <= '0;
         last_beep_ff  <= '0;
         held_ff       <= 1'b0;
         phase_ff      <= pcl_pkg::PHASE_IDLE;
         wait_left_ff  <= pcl_pkg::WAIT_LEFT_RESET;
         walk_left_ff  <= pcl_pkg::WALK_LEFT_RESET;
         clear_left_ff <= '0;
         lamps_ff      <= pcl_pkg::LAMPS_OFF;
         disp_mode_ff  <= pcl_pkg::DISP_BLANK;
         disp_value_ff <= '0;
      end else if (tick_en) begin
         time_ff       <= time_in;
         last_press_ff <= last_press_in;
         last_step_ff  <= last_step_in;
         last_beep_ff  <= last_beep_in;
         held_ff       <= held_in;
         phase_ff      <= phase_in;
         wait_left_ff  <= wait_left_in;
         walk_left_ff  <= walk_left_in;
         clear_left_ff <= clear_left_in;
         lamps_ff      <= lamps_in;
         disp_mode_ff  <= disp_mode_in;
         disp_value_ff <= disp_value_in;
      end
   end

endmodule

// File: src/pedestrian_crossing_light_controller.sv
// Pedestrian crossing light controller. Each req_ transfer is one millisecond
// tick carrying the push-button level (0 = pressed); each tick yields exactly one
// rsp_ transfer with the five lamp bits, buzzer start/stop pulses with the tone
// kind, and a display mode and countdown value. Phases run idle (cars green,
// periodic long beep) -> wait countdown from wait_start to 0 -> walk countdown
// from walk_start to 1 with short beeps -> clearance (car red and yellow) for
// step_interval_ms ticks -> idle. Throughput is one tick per clock while the
// output is not held by rsp_ready: the tick is captured in an input register,
// the whole phase/timer update is one pass of combinational logic in pcl_core,
// and the result lands in an output register that drives rsp_valid. The output
// register stalls on rsp_ready without losing ticks; req_ready drops only while
// both registers are full and the output is held. Registers are written through
// the csr_ channel (always ready) and should only change while no tick is in
// flight. Depends on pcl_pkg, the pcl_*_if interfaces, pcl_csr and pcl_core.
`timescale 1ns / 1ps

module pedestrian_crossing_light_controller #(
   // Width of the millisecond time base; all timestamp differences wrap at it.
   parameter int TIME_BITS = pcl_pkg::TIME_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   pcl_req_if.sink    req_bus,
   pcl_rsp_if.source  rsp_bus,
   pcl_csr_if.sink    csr_bus
);

   pcl_pkg::cfg_type cfg;
   pcl_pkg::rsp_type core_result;

   // Input register: one tick waiting for the core.
   logic             in_valid_ff, in_valid_in;
   logic             in_level_ff;

   // Output register: one finished result waiting for the sink.
   logic             out_valid_ff, out_valid_in;
   pcl_pkg::rsp_type out_data_ff;

   logic             advance;   // core may process the held tick this cycle
   logic             tick_en;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign tick_en       = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (tick_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (tick_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_level_ff <= req_bus.button_level;
      end
      if (tick_en) begin
         out_data_ff <= core_result;
      end
   end

   pcl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   pcl_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (tick_en),
      .button_level (in_level_ff),
      .cfg          (cfg),
      .result       (core_result)
   );

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.car_red       = out_data_ff.lamps.car_red;
   assign rsp_bus.car_yellow    = out_data_ff.lamps.car_yellow;
   assign rsp_bus.car_green     = out_data_ff.lamps.car_green;
   assign rsp_bus.ped_red       = out_data_ff.lamps.ped_red;
   assign rsp_bus.ped_green     = out_data_ff.lamps.ped_green;
   assign rsp_bus.beep_start    = out_data_ff.beep_start;
   assign rsp_bus.beep_kind     = out_data_ff.beep_kind;
   assign rsp_bus.beep_stop     = out_data_ff.beep_stop;
   assign rsp_bus.display_mode  = out_data_ff.display_mode;
   assign rsp_bus.display_value = out_data_ff.display_value;

endmodule

// File: src/pcl_checker.sv
// Port-level assertions for the pedestrian crossing light controller, with bind.
// Depends on pcl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pedestrian_crossing_light_controller_macros.svh"

module pcl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           car_red,
   input logic                           car_yellow,
   input logic                           car_green,
   input logic                           ped_green,
   input logic                           beep_start,
   input logic                           beep_kind,
   input logic                           beep_stop,
   input logic [2:0]                     display_mode,
   input logic [pcl_pkg::COUNT_BITS-1:0] display_value
);

   // Pedestrians never get green while cars may move.
   `PCL_ASSERT_IMPLY(a_no_conflict, clock, reset, rsp_valid && ped_green, car_red && !car_green && !car_yellow)

   // Tone kind is only meaningful with a start pulse.
   `PCL_ASSERT_IMPLY(a_kind_with_start, clock, reset, rsp_valid && beep_kind, beep_start)

   // A countdown number shows only in the two countdown modes.
   `PCL_ASSERT_IMPLY(a_value_mode, clock, reset, rsp_valid && display_value != '0, display_mode == pcl_pkg::DISP_WAIT_COUNT || display_mode == pcl_pkg::DISP_WALK_COUNT)

   // A held result keeps its payload.
   `PCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(beep_start) && $stable(beep_stop) && $stable(display_mode) && $stable(car_red))

endmodule

bind pedestrian_crossing_light_controller pcl_checker u_pcl_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .car_red       (rsp_bus.car_red),
   .car_yellow    (rsp_bus.car_yellow),
   .car_green     (rsp_bus.car_green),
   .ped_green     (rsp_bus.ped_green),
   .beep_start    (rsp_bus.beep_start),
   .beep_kind     (rsp_bus.beep_kind),
   .beep_stop     (rsp_bus.beep_stop),
   .display_mode  (rsp_bus.display_mode),
   .display_value (rsp_bus.display_value)
);

// File: bench/pedestrian_crossing_light_controller_tb.sv
// Self-checking bench for the pedestrian crossing light controller: random tick
// traffic against an in-bench model of the crossing phases, lamps, beeps and display.
// Depends on pcl_pkg, the pcl_*_if interfaces and the controller RTL.
`timescale 1ns / 1ps

module pedestrian_crossing_light_controller_tb;

   localparam int TIME_W = pcl_pkg::TIME_BITS_DEFAULT;

   logic clock;
   logic reset;

   pcl_req_if req_bus ();
   pcl_rsp_if rsp_bus ();
   pcl_csr_if csr_bus ();

   pedestrian_crossing_light_controller i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Crossing model: one call per accepted tick, same state as the block.
   // ---------------------------------------------------------------------
   pcl_pkg::cfg_type       timing_cfg;
   logic [TIME_W-1:0]      clock_ms;       // millisecond time base
   logic [TIME_W-1:0]      press_ms;       // last accepted press (debounce anchor)
   logic [TIME_W-1:0]      step_ms;        // last countdown step
   logic [TIME_W-1:0]      beep_ms;        // last periodic beep
   logic                   button_held;
   pcl_pkg::phase_type     phase_q;
   logic signed [4:0]      wait_cnt;       // runs down to -1
   logic [3:0]             walk_cnt;
   logic [15:0]            clear_cnt;
   pcl_pkg::lamp_type      lamps_q;        // lamps hold the last drawn pattern
   pcl_pkg::disp_mode_type mode_q;         // display holds the last picture
   logic [3:0]             value_q;

   function automatic pcl_pkg::rsp_type crossing_tick(input logic level);
      logic [TIME_W-1:0] now;
      pcl_pkg::rsp_type  r;
      now = clock_ms;
      clock_ms = clock_ms + TIME_W'(1);
      r.beep_start = 1'b0;
      r.beep_kind  = pcl_pkg::BEEP_LONG;
      r.beep_stop  = 1'b0;

      // button is ignored altogether during clearance
      if (phase_q != pcl_pkg::PHASE_CLEAR) begin
         if (!level && !button_held &&
             (now - press_ms) > TIME_W'(timing_cfg.debounce_ms)) begin
            button_held = 1'b1;
            press_ms    = now;
            phase_q     = pcl_pkg::PHASE_WAIT;
         end else if (level) begin
            button_held = 1'b0;
         end
      end

      case (phase_q)
         pcl_pkg::PHASE_IDLE: begin
            lamps_q = pcl_pkg::LAMPS_CARS;
            mode_q  = pcl_pkg::DISP_IDLE;
            value_q = '0;
            if ((now - beep_ms) >= TIME_W'(timing_cfg.idle_beep_ms)) begin
               beep_ms      = now;
               r.beep_start = 1'b1;
               r.beep_kind  = pcl_pkg::BEEP_LONG;
            end
         end
         pcl_pkg::PHASE_WAIT: begin
            // lamps untouched here; display keeps its picture until the first step
            if ((now - step_ms) >= TIME_W'(timing_cfg.step_interval_ms)) begin
               step_ms = now;
               if (!wait_cnt[4]) begin
                  mode_q       = pcl_pkg::DISP_WAIT_COUNT;
                  value_q      = wait_cnt[3:0];
                  r.beep_start = 1'b1;
                  r.beep_kind  = pcl_pkg::BEEP_LONG;
                  wait_cnt     = wait_cnt - 5'sd1;
               end else begin
                  phase_q  = pcl_pkg::PHASE_WALK;
                  wait_cnt = {1'b0, timing_cfg.wait_start};
               end
            end
         end
         pcl_pkg::PHASE_WALK: begin
            lamps_q = pcl_pkg::LAMPS_WALK;
            mode_q  = pcl_pkg::DISP_WALK;
            value_q = '0;
            if ((now - step_ms) >= TIME_W'(timing_cfg.step_interval_ms)) begin
               step_ms = now;
               if (walk_cnt != '0) begin
                  mode_q   = pcl_pkg::DISP_WALK_COUNT;
                  value_q  = walk_cnt;
                  walk_cnt = walk_cnt - 4'd1;
               end else begin
                  r.beep_stop = 1'b1;
                  lamps_q     = pcl_pkg::LAMPS_CLEAR;
                  mode_q      = pcl_pkg::DISP_BLANK;
                  value_q     = '0;
                  phase_q     = pcl_pkg::PHASE_CLEAR;
                  walk_cnt    = timing_cfg.walk_start;
                  clear_cnt   = timing_cfg.step_interval_ms;
               end
            end
            // may coincide with the stop above; both pulses then show
            if ((now - beep_ms) >= TIME_W'(timing_cfg.walk_beep_ms)) begin
               beep_ms      = now;
               r.beep_start = 1'b1;
               r.beep_kind  = pcl_pkg::BEEP_SHORT;
            end
         end
         default: begin
            lamps_q = pcl_pkg::LAMPS_CLEAR;
            mode_q  = pcl_pkg::DISP_BLANK;
            value_q = '0;
            if (clear_cnt <= 16'd1) begin
               clear_cnt = '0;
               phase_q   = pcl_pkg::PHASE_IDLE;
            end else begin
               clear_cnt = clear_cnt - 16'd1;
            end
         end
      endcase

      r.lamps         = lamps_q;
      r.display_mode  = mode_q;
      r.display_value = (mode_q == pcl_pkg::DISP_WAIT_COUNT ||
                         mode_q == pcl_pkg::DISP_WALK_COUNT) ? value_q : '0;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Shared bench state
   // ---------------------------------------------------------------------
   bit               pending_levels[$];    // button levels not yet offered
   pcl_pkg::rsp_type expected_outputs[$];  // predicted outputs, oldest first
   int               n_queued  = 0;        // levels pushed by the stimulus
   int               n_checked = 0;        // output transfers seen
   int               n_fail    = 0;
   int               hold_left = 0;        // receiver hold-off, in cycles
   bit               calm      = 1'b0;     // no random idling on either side
   pcl_pkg::rsp_type want;

   // ---------------------------------------------------------------------
   // Tick driver: offers queued levels, predicts each accepted transfer.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_outputs.push_back(crossing_tick(req_bus.button_level));
         end
         // a held transfer stays put until it goes through
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_levels.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
               req_bus.valid        <= 1'b1;
               req_bus.button_level <= pending_levels.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output monitor: field compare against the oldest prediction.
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [3:0] exp_v,
                              input logic [3:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outputs.size() == 0) begin
               $error("output transfer with no tick outstanding");
               n_fail++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("car_red",    4'(want.lamps.car_red),    4'(rsp_bus.car_red));
               check_field("car_yellow", 4'(want.lamps.car_yellow), 4'(rsp_bus.car_yellow));
               check_field("car_green",  4'(want.lamps.car_green),  4'(rsp_bus.car_green));
               check_field("ped_red",    4'(want.lamps.ped_red),    4'(rsp_bus.ped_red));
               check_field("ped_green",  4'(want.lamps.ped_green),  4'(rsp_bus.ped_green));
               check_field("beep_start", 4'(want.beep_start),       4'(rsp_bus.beep_start));
               check_field("beep_kind",  4'(want.beep_kind),        4'(rsp_bus.beep_kind));
               check_field("beep_stop",  4'(want.beep_stop),        4'(rsp_bus.beep_stop));
               check_field("display_mode", 4'(want.display_mode),
                           4'(rsp_bus.display_mode));
               check_field("display_value", want.display_value, rsp_bus.display_value);
            end
            n_checked++;
            // back-pressure bursts: sender keeps going, so both stages fill
            // and req_ready has to drop
            if (n_checked == 300 || n_checked == 620 || n_checked == 940) begin
               hold_left = 64;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 34);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_level(input bit lvl, input int count);
      repeat (count) begin
         pending_levels.push_back(lvl);
         n_queued++;
      end
   endtask

   // every predicted output has come back; allow for the two-stage pipe
   task automatic wait_drained();
      do @(posedge clock); while (n_checked < n_queued);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr valid high; caller drops it after the last write
   task automatic write_reg(input pcl_pkg::csr_index_type idx, input logic [15:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         pcl_pkg::CSR_STEP_INTERVAL: timing_cfg.step_interval_ms = val;
         pcl_pkg::CSR_DEBOUNCE:
            timing_cfg.debounce_ms = val[pcl_pkg::DEBOUNCE_BITS-1:0];
         pcl_pkg::CSR_IDLE_BEEP:     timing_cfg.idle_beep_ms     = val;
         pcl_pkg::CSR_WALK_BEEP:     timing_cfg.walk_beep_ms     = val;
         pcl_pkg::CSR_WAIT_START:
            timing_cfg.wait_start = val[pcl_pkg::COUNT_BITS-1:0];
         pcl_pkg::CSR_WALK_START:
            timing_cfg.walk_start = val[pcl_pkg::COUNT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic load_setting(input logic [15:0] step, input logic [15:0] debounce,
                               input logic [15:0] idle_beep, input logic [15:0] walk_beep,
                               input logic [15:0] wait_first, input logic [15:0] walk_first);
      wait_drained();
      write_reg(pcl_pkg::CSR_STEP_INTERVAL, step);
      write_reg(pcl_pkg::CSR_DEBOUNCE,      debounce);
      write_reg(pcl_pkg::CSR_IDLE_BEEP,     idle_beep);
      write_reg(pcl_pkg::CSR_WALK_BEEP,     walk_beep);
      write_reg(pcl_pkg::CSR_WAIT_START,    wait_first);
      write_reg(pcl_pkg::CSR_WALK_START,    walk_first);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int          phase_no;
      int          target;
      logic [15:0] step, debounce, idle_beep, walk_beep, wait_first, walk_first;

      // known levels on every input from time zero
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.button_level = 1'b1;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = pcl_pkg::CSR_STEP_INTERVAL;
      csr_bus.data         = '0;

      // model state after reset
      timing_cfg.step_interval_ms = pcl_pkg::STEP_INTERVAL_RESET;
      timing_cfg.debounce_ms      = pcl_pkg::DEBOUNCE_RESET;
      timing_cfg.idle_beep_ms     = pcl_pkg::IDLE_BEEP_RESET;
      timing_cfg.walk_beep_ms     = pcl_pkg::WALK_BEEP_RESET;
      timing_cfg.wait_start       = pcl_pkg::WAIT_START_RESET;
      timing_cfg.walk_start       = pcl_pkg::WALK_START_RESET;
      clock_ms    = '0;
      press_ms    = '0;
      step_ms     = '0;
      beep_ms     = '0;
      button_held = 1'b0;
      phase_q     = pcl_pkg::PHASE_IDLE;
      wait_cnt    = pcl_pkg::WAIT_LEFT_RESET;
      walk_cnt    = pcl_pkg::WALK_LEFT_RESET;
      clear_cnt   = '0;
      lamps_q     = pcl_pkg::LAMPS_OFF;
      mode_q      = pcl_pkg::DISP_BLANK;
      value_q     = '0;

      // default registers: a press right after reset falls inside the debounce
      // window and must be ignored
      push_level(1'b0, 2);
      push_level(1'b1, 1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero step interval and zero beep periods: every tick steps and beeps,
      // clearance lasts one tick
      load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd2);
      push_level(1'b0, 1);    // press from idle
      push_level(1'b1, 8);    // wait countdown from the reset value, into walk
      push_level(1'b0, 1);    // press again while walking: back to wait
      push_level(1'b1, 6);    // short wait, walk, walk end with stop and beep
      push_level(1'b0, 2);    // low across clearance (unsampled), then a press
      push_level(1'b1, 1);

      // all-ones extremes: long periods, widest debounce, top counts
      load_setting(16'hFFFF, 16'd1023, 16'hFFFF, 16'hFFFF, 16'd15, 16'd15);
      repeat (30) push_level($urandom_range(1) != 0, 1);

      // random part: short periods so whole crossings fit in a few dozen ticks
      phase_no = 0;
      while (n_queued < 1150) begin
         step       = 16'(($urandom_range(99) < 85) ? $urandom_range(6)
                                                     : $urandom_range(40, 7));
         debounce   = 16'(($urandom_range(99) < 95) ? $urandom_range(15) : 1023);
         idle_beep  = 16'($urandom_range(15));
         walk_beep  = 16'($urandom_range(8));
         wait_first = 16'(($urandom_range(99) < 90) ? $urandom_range(5) : 15);
         walk_first = 16'(($urandom_range(99) < 90) ? $urandom_range(5) : 15);
         load_setting(step, debounce, idle_beep, walk_beep, wait_first, walk_first);

         // one phase runs with both sides streaming
         calm   = (phase_no == 3);
         target = n_queued + int'($urandom_range(160, 80));
         if (target > 1150) begin
            target = 1150;
         end
         while (n_queued < target) begin
            if ($urandom_range(9) < 8) begin
               // clean press, released long enough to see much of the cycle
               push_level(1'b0, $urandom_range(3, 1));
               push_level(1'b1, $urandom_range(90, 2));
            end else begin
               // contact bounce
               repeat ($urandom_range(8, 1)) push_level($urandom_range(1) != 0, 1);
            end
         end
         phase_no++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (n_fail == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/pcl_pkg.sv
src/pcl_ifs.sv
src/pcl_csr.sv
src/pcl_core.sv
src/pedestrian_crossing_light_controller.sv
src/pcl_checker.sv
bench/pedestrian_crossing_light_controller_tb.sv
